[src/first_worst_fit_allocator_assert.svh]
// Assertion macros used by the checker file
`ifndef FIRST_WORST_FIT_ALLOCATOR_ASSERT_SVH
`define FIRST_WORST_FIT_ALLOCATOR_ASSERT_SVH

// Implication checked on every clock edge outside reset
`define FWF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset
`define FWF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[src/fwfa_pkg.sv]
package fwfa_pkg;
    localparam int MEM_UNITS  = 16384;
    localparam int MAX_HOLES  = 32;
    localparam int MAX_OWNERS = 64;
    localparam int HW = $clog2(MAX_HOLES);
    localparam int OW = 6;
    localparam int SW = 14;
    localparam int LW = 15;
    localparam logic [LW-1:0] POOL_RESET = 15'd10000;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NOFIT   = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_NOOWNER = 3'd3;
    localparam logic [2:0] ST_DOUBLE  = 3'd4;

    localparam int REG_POLICY = 0;
    localparam int REG_POOL   = 1;

    typedef struct packed {
        logic             kind;
        logic [OW-1:0]    owner;
        logic [LW-1:0]    size;
    } t_req;

    typedef struct packed {
        logic [2:0]       status;
        logic [SW-1:0]    start_res;
        logic [LW-1:0]    length;
    } t_rsp;
endpackage

[src/fwfa_req_if.sv]
interface fwfa_req_if;
    logic           valid;
    logic           ready;
    fwfa_pkg::t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[src/fwfa_rsp_if.sv]
interface fwfa_rsp_if;
    logic           valid;
    logic           ready;
    fwfa_pkg::t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[src/fwfa_ram.sv]
// Generic single-port RAM, registered read
module fwfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

[src/first_worst_fit_allocator.sv]
// From request transfer to response valid, a request passes through S_RD, a scan of the hole
// table (one entry per cycle through a shared compare/add unit), S_UPD, S_UPD2 and S_OUT;
// a double allocate, a zero size or a free of an unknown owner goes from S_RD to S_OUT.
// Throughput: one request at a time; ready returns the cycle after the response transfer.
// Synchronous active-low reset: policy 0, pool 10000, one hole [0,pool), all regions free.
// A pool_size write reloads the tables.
module first_worst_fit_allocator (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [0:0]             i_cfg_idx,
    input  logic [14:0]            i_cfg_wdata,
    fwfa_req_if.sink               req,
    fwfa_rsp_if.source             rsp
);
    localparam int HW = fwfa_pkg::HW;
    localparam int SW = fwfa_pkg::SW;
    localparam int LW = fwfa_pkg::LW;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RD   = 6'b000010,
        S_SCAN = 6'b000100,
        S_UPD  = 6'b001000,
        S_UPD2 = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // Configuration and hole table (small, read at a scanned index)
    logic                 r_policy;
    logic [SW-1:0]        r_hs [fwfa_pkg::MAX_HOLES];
    logic [LW-1:0]        r_hl [fwfa_pkg::MAX_HOLES];
    logic [fwfa_pkg::MAX_HOLES-1:0] r_hv;
    logic [fwfa_pkg::MAX_OWNERS-1:0] r_rv;

    fwfa_pkg::t_req r_req;
    fwfa_pkg::t_rsp r_rsp;
    logic           r_rsp_v;

    logic [HW:0]   r_idx;
    logic [HW-1:0] r_best, r_prev, r_next, r_slot;
    logic          r_hb, r_hp, r_hn, r_hsl;
    logic [SW-1:0] r_s;
    logic [LW-1:0] r_l;

    // Region store: start and length in one RAM, read data registered
    logic                 ram_we;
    logic [SW+LW-1:0]     ram_rd;
    logic [SW-1:0]        rg_s;
    logic [LW-1:0]        rg_l;

    fwfa_ram #(.WIDTH(SW+LW), .DEPTH(fwfa_pkg::MAX_OWNERS)) u_region (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (r_req.owner),
        .i_wdata({r_hs[r_best], r_req.size}),
        .o_rdata(ram_rd)
    );
    assign rg_s = ram_rd[SW+LW-1:LW];
    assign rg_l = ram_rd[LW-1:0];
    assign ram_we = (r_state == S_UPD) && !r_req.kind && r_hb;

    // Shared scan unit: one hole entry per cycle
    logic [HW-1:0] cur;
    logic [LW:0]   cur_end;
    logic [LW:0]   reg_end;
    logic          fits, better;
    assign cur     = r_idx[HW-1:0];
    assign cur_end = (LW+1)'(r_hs[cur]) + (LW+1)'(r_hl[cur]);
    assign reg_end = (LW+1)'(rg_s) + (LW+1)'(rg_l);
    assign fits    = r_hv[cur] && (r_hl[cur] >= r_req.size);
    always_comb begin
        if (!r_policy) begin
            better = r_hs[cur] < r_hs[r_best];
        end else begin
            better = (r_hl[cur] > r_hl[r_best]) ||
                     ((r_hl[cur] == r_hl[r_best]) && (r_hs[cur] < r_hs[r_best]));
        end
    end

    assign req.ready = (r_state == S_IDLE) && !r_rsp_v;
    assign rsp.valid = r_rsp_v;
    assign rsp.data  = r_rsp;

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (req.valid && req.ready) n_state = S_RD;
            S_RD: begin
                if (r_req.kind ? !r_rv[r_req.owner]
                               : (r_rv[r_req.owner] || r_req.size == '0)) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: if (r_idx == (HW+1)'(fwfa_pkg::MAX_HOLES - 1)) n_state = S_UPD;
            S_UPD:  n_state = S_UPD2;
            S_UPD2: n_state = S_OUT;
            S_OUT:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    logic [LW-1:0] cfg_pool;
    always_comb begin
        cfg_pool = i_cfg_wdata;
        if (cfg_pool == '0) cfg_pool = LW'(1);
        if (cfg_pool > LW'(fwfa_pkg::MEM_UNITS)) cfg_pool = LW'(fwfa_pkg::MEM_UNITS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_policy <= 1'b0;
            r_hv     <= {{(fwfa_pkg::MAX_HOLES-1){1'b0}}, 1'b1};
            r_hs[0]  <= '0;
            r_hl[0]  <= fwfa_pkg::POOL_RESET;
            r_rv     <= '0;
            r_rsp_v  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (rsp.valid && rsp.ready) r_rsp_v <= 1'b0;
            // Configuration writes must arrive only while idle; the block itself does not enforce it
            if (i_cfg_we && i_cfg_idx == 1'(fwfa_pkg::REG_POLICY)) r_policy <= i_cfg_wdata[0];
            if (i_cfg_we && i_cfg_idx == 1'(fwfa_pkg::REG_POOL)) begin
                r_hv    <= {{(fwfa_pkg::MAX_HOLES-1){1'b0}}, 1'b1};
                r_hs[0] <= '0;
                r_hl[0] <= cfg_pool;
                r_rv    <= '0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (req.valid && req.ready) r_req <= req.data;
                    r_idx <= '0;
                    r_hb <= 1'b0; r_hp <= 1'b0; r_hn <= 1'b0; r_hsl <= 1'b0;
                    r_best <= '0;
                end
                S_RD: begin
                    r_rsp.start_res <= '0;
                    r_rsp.length    <= '0;
                    if (r_req.kind) r_rsp.status <= fwfa_pkg::ST_NOOWNER;
                    else if (r_rv[r_req.owner]) r_rsp.status <= fwfa_pkg::ST_DOUBLE;
                    else r_rsp.status <= fwfa_pkg::ST_NOFIT;
                end
                S_SCAN: begin
                    r_idx <= r_idx + 1'b1;
                    if (!r_req.kind) begin
                        if (fits && (!r_hb || better)) begin
                            r_best <= cur;
                            r_hb   <= 1'b1;
                        end
                    end else if (!r_hv[cur]) begin
                        if (!r_hsl) begin r_slot <= cur; r_hsl <= 1'b1; end
                    end else if (!r_hp && cur_end == (LW+1)'(rg_s)) begin
                        r_prev <= cur; r_hp <= 1'b1;
                    end else if (!r_hn && (LW+1)'(r_hs[cur]) == reg_end) begin
                        r_next <= cur; r_hn <= 1'b1;
                    end
                end
                S_UPD: begin
                    r_s <= rg_s;
                    r_l <= rg_l;
                    if (!r_req.kind) begin
                        if (r_hb) begin
                            r_rv[r_req.owner]  <= 1'b1;
                            r_rsp.status       <= fwfa_pkg::ST_OK;
                            r_rsp.start_res    <= r_hs[r_best];
                            r_rsp.length       <= r_req.size;
                            r_hl[r_best] <= r_hl[r_best] - r_req.size;
                            if (r_hl[r_best] == r_req.size) begin
                                r_hv[r_best] <= 1'b0;
                                r_hs[r_best] <= '0;
                            end else begin
                                r_hs[r_best] <= SW'(LW'(r_hs[r_best]) + r_req.size);
                            end
                        end
                    end
                end
                S_UPD2: begin
                    if (r_req.kind) begin
                        priority if (r_hp && r_hn) begin
                            r_hl[r_prev] <= r_hl[r_prev] + r_l + r_hl[r_next];
                            r_hv[r_next] <= 1'b0;
                            r_hs[r_next] <= '0;
                            r_hl[r_next] <= '0;
                        end else if (r_hp) begin
                            r_hl[r_prev] <= r_hl[r_prev] + r_l;
                        end else if (r_hn) begin
                            r_hs[r_next] <= r_s;
                            r_hl[r_next] <= r_hl[r_next] + r_l;
                        end else if (r_hsl) begin
                            r_hs[r_slot] <= r_s;
                            r_hl[r_slot] <= r_l;
                            r_hv[r_slot] <= 1'b1;
                        end
                        if (r_hp || r_hn || r_hsl) begin
                            r_rv[r_req.owner] <= 1'b0;
                            r_rsp.status      <= fwfa_pkg::ST_OK;
                            r_rsp.start_res   <= r_s;
                            r_rsp.length      <= r_l;
                        end else begin
                            r_rsp.status      <= fwfa_pkg::ST_FULL;
                        end
                    end
                end
                S_OUT: r_rsp_v <= 1'b1;
                default: ;
            endcase
        end
    end
endmodule

[src/fwfa_checker.sv]
`include "first_worst_fit_allocator_assert.svh"
// Port-level checks on the allocator
module fwfa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [2:0]  status,
    input logic [14:0] length
);
    `FWF_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, rsp_valid, !req_ready)
    `FWF_ASSERT_IMP(a_err_zero_len, i_clk, i_rst_n,
        rsp_valid && status != fwfa_pkg::ST_OK, length == '0)
    `FWF_ASSERT_IMP(a_status_range, i_clk, i_rst_n, rsp_valid,
        status == fwfa_pkg::ST_OK || status == fwfa_pkg::ST_NOFIT ||
        status == fwfa_pkg::ST_FULL || status == fwfa_pkg::ST_NOOWNER ||
        status == fwfa_pkg::ST_DOUBLE)
    `FWF_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, req_valid && req_ready,
        !req_ready)
endmodule

bind first_worst_fit_allocator fwfa_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .req_valid(req.valid), .req_ready(req.ready),
    .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
    .status(rsp.data.status), .length(rsp.data.length)
);

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;
    localparam int   CYCLE_LIMIT = 1000000;
    localparam int   SETTLE = fwfa_pkg::MAX_HOLES + 20;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [0:0]  i_cfg_idx;
    logic [14:0] i_cfg_wdata;

    fwfa_req_if req_ch ();
    fwfa_rsp_if rsp_ch ();

    first_worst_fit_allocator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .req         (req_ch),
        .rsp         (rsp_ch)
    );

    // Shadow allocator state
    int  m_policy;
    int  m_pool;
    int  hole_st[fwfa_pkg::MAX_HOLES];
    int  hole_len[fwfa_pkg::MAX_HOLES];
    bit  hole_ok[fwfa_pkg::MAX_HOLES];
    int  reg_st[fwfa_pkg::MAX_OWNERS];
    int  reg_len[fwfa_pkg::MAX_OWNERS];
    bit  reg_ok[fwfa_pkg::MAX_OWNERS];

    fwfa_pkg::t_rsp rsp_expected[$];
    int   n_errors = 0;
    int   n_checked = 0;
    int   n_sent = 0;
    int   n_cycles = 0;
    bit   long_hold = 0;

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Run limit
    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", n_cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic void clear_tables();
        for (int i = 0; i < fwfa_pkg::MAX_HOLES; i++) begin
            hole_st[i] = 0;
            hole_len[i] = 0;
            hole_ok[i] = 0;
        end
        for (int i = 0; i < fwfa_pkg::MAX_OWNERS; i++) begin
            reg_st[i] = 0;
            reg_len[i] = 0;
            reg_ok[i] = 0;
        end
        hole_len[0] = m_pool;
        hole_ok[0] = 1;
    endfunction

    function automatic int choose_hole(int need);
        int pick;
        pick = -1;
        for (int i = 0; i < fwfa_pkg::MAX_HOLES; i++) begin
            if (!hole_ok[i] || hole_len[i] < need) continue;
            if (pick < 0) pick = i;
            else if (m_policy == 0) begin
                if (hole_st[i] < hole_st[pick]) pick = i;
            end else if (hole_len[i] > hole_len[pick] ||
                         (hole_len[i] == hole_len[pick] && hole_st[i] < hole_st[pick])) begin
                pick = i;
            end
        end
        return pick;
    endfunction

    // Apply one request to the shadow state and return the expected response
    function automatic fwfa_pkg::t_rsp allocate_or_free(fwfa_pkg::t_req r);
        fwfa_pkg::t_rsp o;
        int   w, h, s, l, e, prv, nxt, slot;
        o = '0;
        w = int'(r.owner);
        s = 0;
        l = 0;
        if (r.kind == KIND_ALLOC) begin
            if (reg_ok[w]) o.status = fwfa_pkg::ST_DOUBLE;
            else if (r.size == 0) o.status = fwfa_pkg::ST_NOFIT;
            else begin
                h = choose_hole(int'(r.size));
                if (h < 0) o.status = fwfa_pkg::ST_NOFIT;
                else begin
                    o.status = fwfa_pkg::ST_OK;
                    s = hole_st[h];
                    l = int'(r.size);
                    reg_st[w] = s;
                    reg_len[w] = l;
                    reg_ok[w] = 1;
                    hole_st[h] += l;
                    hole_len[h] -= l;
                    if (hole_len[h] == 0) begin
                        hole_ok[h] = 0;
                        hole_st[h] = 0;
                    end
                end
            end
        end else if (!reg_ok[w]) begin
            o.status = fwfa_pkg::ST_NOOWNER;
        end else begin
            prv = -1;
            nxt = -1;
            slot = -1;
            s = reg_st[w];
            l = reg_len[w];
            e = s + l;
            for (int i = 0; i < fwfa_pkg::MAX_HOLES; i++) begin
                if (!hole_ok[i]) begin
                    if (slot < 0) slot = i;
                end else if (prv < 0 && hole_st[i] + hole_len[i] == s) prv = i;
                else if (nxt < 0 && hole_st[i] == e) nxt = i;
            end
            o.status = fwfa_pkg::ST_OK;
            if (prv >= 0 && nxt >= 0) begin
                hole_len[prv] += l + hole_len[nxt];
                hole_ok[nxt] = 0;
                hole_st[nxt] = 0;
                hole_len[nxt] = 0;
            end else if (prv >= 0) begin
                hole_len[prv] += l;
            end else if (nxt >= 0) begin
                hole_st[nxt] = s;
                hole_len[nxt] += l;
            end else if (slot >= 0) begin
                hole_st[slot] = s;
                hole_len[slot] = l;
                hole_ok[slot] = 1;
            end else begin
                o.status = fwfa_pkg::ST_FULL;
            end
            if (o.status == fwfa_pkg::ST_OK) reg_ok[w] = 0;
        end
        if (o.status == fwfa_pkg::ST_OK) begin
            o.start_res = s[fwfa_pkg::SW-1:0];
            o.length = l[fwfa_pkg::LW-1:0];
        end
        return o;
    endfunction

    // Offer one request after a random gap; valid stays high after the transfer
    task automatic send_req(logic kind, int owner, int size);
        fwfa_pkg::t_req r;
        int   gap;
        gap = $urandom_range(0, 7);
        r.kind = kind;
        r.owner = owner[fwfa_pkg::OW-1:0];
        r.size = size[fwfa_pkg::LW-1:0];
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data <= r;
        do @(posedge i_clk); while (!req_ch.ready);
        rsp_expected.push_back(allocate_or_free(r));
        n_sent++;
    endtask

    // Stop offering and let every outstanding response arrive
    task automatic drain();
        req_ch.valid <= 1'b0;
        while (rsp_expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_cfg(int idx, int value);
        int v;
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx[0:0];
        i_cfg_wdata <= value[14:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == fwfa_pkg::REG_POLICY) m_policy = value & 1;
        else begin
            v = value & 16'h7FFF;
            if (v == 0) v = 1;
            if (v > fwfa_pkg::MEM_UNITS) v = fwfa_pkg::MEM_UNITS;
            m_pool = v;
            clear_tables();
        end
        @(posedge i_clk);
    endtask

    // Response side: random stalls, one long hold when asked
    initial begin
        int   stall;
        fwfa_pkg::t_rsp want;
        rsp_ch.ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (long_hold) begin
                rsp_ch.ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                long_hold = 0;
            end else begin
                stall = $urandom_range(0, 7);
                if (stall > 0) begin
                    rsp_ch.ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_ch.valid);
            n_checked++;
            if (rsp_expected.size() == 0) begin
                $error("response with nothing expected: %p", rsp_ch.data);
                n_errors++;
            end else begin
                want = rsp_expected.pop_front();
                if (rsp_ch.data.status !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, rsp_ch.data.status);
                    n_errors++;
                end
                if (rsp_ch.data.start_res !== want.start_res) begin
                    $error("start_res expected %0d actual %0d",
                           want.start_res, rsp_ch.data.start_res);
                    n_errors++;
                end
                if (rsp_ch.data.length !== want.length) begin
                    $error("length expected %0d actual %0d", want.length, rsp_ch.data.length);
                    n_errors++;
                end
            end
        end
    end

    // Extremes of size, double allocate, unknown free, merges on both sides
    task automatic test_directed();
        write_cfg(fwfa_pkg::REG_POOL, 10000);
        send_req(KIND_ALLOC, 0, 0);
        send_req(KIND_ALLOC, 0, 32767);
        send_req(KIND_ALLOC, 0, 16384);
        send_req(KIND_FREE, 5, 0);
        send_req(KIND_ALLOC, 0, 100);
        send_req(KIND_ALLOC, 0, 100);
        send_req(KIND_ALLOC, 1, 200);
        send_req(KIND_ALLOC, 2, 300);
        send_req(KIND_ALLOC, 63, 9400);
        send_req(KIND_ALLOC, 3, 1);
        send_req(KIND_FREE, 1, 32767);
        send_req(KIND_FREE, 0, 0);
        send_req(KIND_FREE, 63, 0);
        send_req(KIND_FREE, 2, 0);
        send_req(KIND_FREE, 2, 0);
        write_cfg(fwfa_pkg::REG_POLICY, 1);
        send_req(KIND_ALLOC, 10, 10000);
        send_req(KIND_FREE, 10, 0);
        send_req(KIND_ALLOC, 11, 1);
        send_req(KIND_ALLOC, 12, 5000);
        send_req(KIND_ALLOC, 13, 4999);
        send_req(KIND_ALLOC, 14, 1);
        write_cfg(fwfa_pkg::REG_POLICY, 0);
    endtask

    // Fill the hole table, then free an isolated region
    task automatic test_table_full();
        write_cfg(fwfa_pkg::REG_POOL, 100);
        for (int i = 0; i < fwfa_pkg::MAX_OWNERS; i++) send_req(KIND_ALLOC, i, 1);
        for (int i = 0; i < 62; i += 2) send_req(KIND_FREE, i, 0);
        send_req(KIND_FREE, 62, 0);
        send_req(KIND_FREE, 1, 0);
        send_req(KIND_FREE, 62, 0);
    endtask

    // Mostly well-formed alloc/free traffic, some fully random noise
    task automatic test_random(int n, int pol, int pool);
        int  w, sz, cap;
        logic k;
        write_cfg(fwfa_pkg::REG_POLICY, pol);
        write_cfg(fwfa_pkg::REG_POOL, pool);
        cap = (m_pool / 6) + 1;
        for (int i = 0; i < n; i++) begin
            w = $urandom_range(0, fwfa_pkg::MAX_OWNERS - 1);
            if ($urandom_range(0, 9) == 0) begin
                k = 1'($urandom_range(0, 1));
                sz = $urandom_range(0, 32767);
            end else begin
                k = reg_ok[w] ? ($urandom_range(0, 2) != 0) : KIND_ALLOC;
                sz = $urandom_range(1, cap);
                if ($urandom_range(0, 19) == 0) sz = $urandom_range(0, 16384);
            end
            send_req(k, w, sz);
        end
    endtask

    // Receiver holds off while requests keep coming
    task automatic test_backpressure();
        write_cfg(fwfa_pkg::REG_POOL, 2000);
        long_hold = 1;
        for (int i = 0; i < 40; i++)
            send_req(1'($urandom_range(0, 1)), $urandom_range(0, fwfa_pkg::MAX_OWNERS - 1),
                     $urandom_range(1, 200));
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= '0;
        i_cfg_wdata <= '0;
        req_ch.valid <= 1'b0;
        req_ch.data <= '0;
        m_policy = 0;
        m_pool = int'(fwfa_pkg::POOL_RESET);
        clear_tables();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // traffic straight out of reset
        send_req(KIND_ALLOC, 7, 10000);
        send_req(KIND_ALLOC, 8, 1);
        send_req(KIND_FREE, 7, 0);
        test_directed();
        test_table_full();
        test_backpressure();
        test_random(300, 0, 10000);
        test_random(300, 1, 16384);
        test_random(60, 0, 0);
        test_random(200, 1, 32767);
        test_random(200, 0, 300);
        test_random(200, 1, 64);
        test_random(100, 0, 1);
        drain();

        $display("covered %0d requests, %0d responses checked, both placement policies",
                 n_sent, n_checked);
        $display("pools from 1 to 16384 incl. clamped writes, full hole table, long stall");
        if (n_errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
